@@ sv/lsrc_pkg.sv @@
// Shared types, widths and pipeline stage indices for the line segment clipper.
package lsrc_pkg;

  // Coordinate formats.
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned SIZE_W     = COORD_W - 1;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned EDGE_W     = COORD_W + 2;
  localparam int unsigned MAG_W      = COORD_W;

  // Clip parameters are unsigned Q1.RATIO_BITS.
  localparam int unsigned RATIO_BITS = 16;
  localparam int unsigned T_W        = RATIO_BITS + 1;
  localparam logic [T_W-1:0] T_ONE   = {1'b1, {RATIO_BITS{1'b0}}};

  // One quotient bit per divider stage.
  localparam int unsigned DIV_STEPS  = T_W;

  // Edge order of the clip tests.
  localparam int unsigned NUM_EDGES   = 4;
  localparam int unsigned EDGE_LEFT   = 0;
  localparam int unsigned EDGE_RIGHT  = 1;
  localparam int unsigned EDGE_TOP    = 2;
  localparam int unsigned EDGE_BOTTOM = 3;

  // Pipeline stage indices.
  localparam int unsigned ST_PREP  = 0;
  localparam int unsigned ST_CLASS = 1;
  localparam int unsigned ST_DIV0  = 2;
  localparam int unsigned ST_DIVN  = ST_DIV0 + DIV_STEPS - 1;
  localparam int unsigned ST_SEL   = ST_DIVN + 1;
  localparam int unsigned ST_MUL   = ST_SEL + 1;
  localparam int unsigned ST_OUT   = ST_MUL + 1;
  localparam int unsigned NUM_ST   = ST_OUT + 1;

  // Input beat: one segment and one clip rectangle.
  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] clip_left;
    logic signed [COORD_W-1:0] clip_top;
    logic        [SIZE_W-1:0]  clip_width;
    logic        [SIZE_W-1:0]  clip_height;
  } in_beat_t;

  // Output beat: visible flag and clipped endpoints.
  typedef struct packed {
    logic                      visible;
    logic signed [COORD_W-1:0] clipped_start_x;
    logic signed [COORD_W-1:0] clipped_start_y;
    logic signed [COORD_W-1:0] clipped_end_x;
    logic signed [COORD_W-1:0] clipped_end_y;
  } out_beat_t;

endpackage

@@ sv/lsrc_divider.sv @@
// Pipelined restoring divider: floor(num * 2^RATIO_BITS / den) for num <= den.
module lsrc_divider (
  input  logic                                clk_i,
  input  logic [lsrc_pkg::DIV_STEPS-1:0]      en_i,
  input  logic [lsrc_pkg::MAG_W-1:0]          num_i,
  input  logic [lsrc_pkg::MAG_W-1:0]          den_i,
  output logic [lsrc_pkg::T_W-1:0]            quot_o
);

  logic [lsrc_pkg::MAG_W-1:0] rem_q  [lsrc_pkg::DIV_STEPS];
  logic [lsrc_pkg::T_W-1:0]   quot_q [lsrc_pkg::DIV_STEPS];
  logic [lsrc_pkg::MAG_W-1:0] den_q  [lsrc_pkg::DIV_STEPS-1];

  // Each stage settles one quotient bit, most significant first. The first
  // stage compares the numerator itself, the later ones the doubled remainder.
  for (genvar j = 0; j < lsrc_pkg::DIV_STEPS; j++) begin : g_step
    logic [lsrc_pkg::MAG_W:0]   sh;
    logic [lsrc_pkg::MAG_W+1:0] diff;
    logic                       ge;
    logic [lsrc_pkg::MAG_W-1:0] den_in;
    logic [lsrc_pkg::T_W-1:0]   quot_in;

    if (j == 0) begin : g_first
      assign sh      = {1'b0, num_i};
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign sh      = {rem_q[j-1], 1'b0};
      assign den_in  = den_q[j-1];
      assign quot_in = quot_q[j-1];
    end

    assign diff = {1'b0, sh} - {2'b00, den_in};
    assign ge   = ~diff[lsrc_pkg::MAG_W+1];

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j]  <= ge ? diff[lsrc_pkg::MAG_W-1:0] : sh[lsrc_pkg::MAG_W-1:0];
        quot_q[j] <= {quot_in[lsrc_pkg::T_W-2:0], ge};
      end
    end

    // The divisor only travels as far as a later stage needs it.
    if (j < lsrc_pkg::DIV_STEPS - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i[j]) begin
          den_q[j] <= den_in;
        end
      end
    end
  end

  assign quot_o = quot_q[lsrc_pkg::DIV_STEPS-1];

endmodule

@@ sv/line_segment_rect_clipper.sv @@
// Liang-Barsky line segment clipper against an axis-aligned rectangle, top level.
// Throughput: one segment per cycle while out_stall_i is low; four 17-stage pipelined
// dividers, one quotient bit per stage, make up most of the 22 registered stages.
// A stalled output holds its beat while empty stages upstream keep filling.
// Reset clears only the stage valid bits; the data registers are not reset.
module line_segment_rect_clipper (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lsrc_pkg::in_beat_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lsrc_pkg::out_beat_t   out_data_o
);

  // Side data that travels alongside the dividers.
  typedef struct packed {
    logic signed [lsrc_pkg::COORD_W-1:0] sx;
    logic signed [lsrc_pkg::COORD_W-1:0] sy;
    logic signed [lsrc_pkg::DIFF_W-1:0]  dx;
    logic signed [lsrc_pkg::DIFF_W-1:0]  dy;
    logic [lsrc_pkg::NUM_EDGES-1:0]      use_in;
    logic [lsrc_pkg::NUM_EDGES-1:0]      use_out;
    logic                                rej;
  } side_t;

  localparam int unsigned PROD_W = lsrc_pkg::T_W + 1 + lsrc_pkg::DIFF_W;

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its content moves on.
  // ---------------------------------------------------------------------------
  logic [lsrc_pkg::NUM_ST-1:0] valid_q;
  logic [lsrc_pkg::NUM_ST-1:0] valid_d;
  logic [lsrc_pkg::NUM_ST:0]   adv;

  always_comb begin
    adv[lsrc_pkg::NUM_ST] = ~out_stall_i;
    for (int k = lsrc_pkg::NUM_ST - 1; k >= 0; k--) begin
      adv[k] = ~valid_q[k] | adv[k+1];
    end
  end

  assign valid_d = (adv[lsrc_pkg::NUM_ST-1:0] & {valid_q[lsrc_pkg::NUM_ST-2:0], in_valid_i})
                 | (~adv[lsrc_pkg::NUM_ST-1:0] & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = ~adv[lsrc_pkg::ST_PREP];
  assign out_valid_o = valid_q[lsrc_pkg::ST_OUT];

  // ---------------------------------------------------------------------------
  // Prep stage: segment deltas and edge distances q.
  // ---------------------------------------------------------------------------
  logic signed [lsrc_pkg::COORD_W-1:0] prep_sx_q, prep_sy_q;
  logic signed [lsrc_pkg::DIFF_W-1:0]  prep_dx_q, prep_dy_q;
  logic signed [lsrc_pkg::EDGE_W-1:0]  prep_q_q [lsrc_pkg::NUM_EDGES];
  logic signed [lsrc_pkg::EDGE_W-1:0]  prep_q_d [lsrc_pkg::NUM_EDGES];
  logic [lsrc_pkg::EDGE_W-1:0]         ext_sx, ext_sy, ext_cl, ext_ct, ext_cw, ext_ch;

  always_comb begin
    ext_sx = lsrc_pkg::EDGE_W'(in_data_i.start_x);
    ext_sy = lsrc_pkg::EDGE_W'(in_data_i.start_y);
    ext_cl = lsrc_pkg::EDGE_W'(in_data_i.clip_left);
    ext_ct = lsrc_pkg::EDGE_W'(in_data_i.clip_top);
    ext_cw = lsrc_pkg::EDGE_W'(in_data_i.clip_width);
    ext_ch = lsrc_pkg::EDGE_W'(in_data_i.clip_height);
    prep_q_d[lsrc_pkg::EDGE_LEFT]   = ext_sx - ext_cl;
    prep_q_d[lsrc_pkg::EDGE_RIGHT]  = ext_cl + ext_cw - ext_sx;
    prep_q_d[lsrc_pkg::EDGE_TOP]    = ext_sy - ext_ct;
    prep_q_d[lsrc_pkg::EDGE_BOTTOM] = ext_ct + ext_ch - ext_sy;
  end

  always_ff @(posedge clk_i) begin
    if (adv[lsrc_pkg::ST_PREP]) begin
      prep_sx_q <= in_data_i.start_x;
      prep_sy_q <= in_data_i.start_y;
      prep_dx_q <= lsrc_pkg::DIFF_W'(in_data_i.end_x) - lsrc_pkg::DIFF_W'(in_data_i.start_x);
      prep_dy_q <= lsrc_pkg::DIFF_W'(in_data_i.end_y) - lsrc_pkg::DIFF_W'(in_data_i.start_y);
      prep_q_q  <= prep_q_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Classify stage: sort each edge into entry, exit, parallel or reject, and
  // form the divider operands |q| and |p|.
  // ---------------------------------------------------------------------------
  side_t                       cls_side_d, cls_side_q;
  logic [lsrc_pkg::MAG_W-1:0]  cls_a_d [lsrc_pkg::NUM_EDGES];
  logic [lsrc_pkg::MAG_W-1:0]  cls_b_d [lsrc_pkg::NUM_EDGES];
  logic [lsrc_pkg::MAG_W-1:0]  cls_a_q [lsrc_pkg::NUM_EDGES];
  logic [lsrc_pkg::MAG_W-1:0]  cls_b_q [lsrc_pkg::NUM_EDGES];

  always_comb begin
    logic [lsrc_pkg::DIFF_W-1:0] mag_x, mag_y, mag_p;
    logic [lsrc_pkg::EDGE_W-1:0] mag_q;
    logic                        d_pos, d_neg, p_neg, p_pos, p_zero, q_neg, q_zero;
    logic                        a_le_b, a_lt_b;

    mag_x = prep_dx_q[lsrc_pkg::DIFF_W-1] ? -prep_dx_q : prep_dx_q;
    mag_y = prep_dy_q[lsrc_pkg::DIFF_W-1] ? -prep_dy_q : prep_dy_q;

    cls_side_d.sx  = prep_sx_q;
    cls_side_d.sy  = prep_sy_q;
    cls_side_d.dx  = prep_dx_q;
    cls_side_d.dy  = prep_dy_q;
    cls_side_d.rej = 1'b0;

    for (int k = 0; k < lsrc_pkg::NUM_EDGES; k++) begin
      // Left and top use p = -d, right and bottom p = d.
      if (k == lsrc_pkg::EDGE_LEFT || k == lsrc_pkg::EDGE_RIGHT) begin
        d_pos = ~prep_dx_q[lsrc_pkg::DIFF_W-1] && (prep_dx_q != '0);
        d_neg = prep_dx_q[lsrc_pkg::DIFF_W-1];
        mag_p = mag_x;
      end else begin
        d_pos = ~prep_dy_q[lsrc_pkg::DIFF_W-1] && (prep_dy_q != '0);
        d_neg = prep_dy_q[lsrc_pkg::DIFF_W-1];
        mag_p = mag_y;
      end
      if (k == lsrc_pkg::EDGE_LEFT || k == lsrc_pkg::EDGE_TOP) begin
        p_neg = d_pos;
        p_pos = d_neg;
      end else begin
        p_neg = d_neg;
        p_pos = d_pos;
      end
      p_zero = ~p_neg & ~p_pos;

      q_neg  = prep_q_q[k][lsrc_pkg::EDGE_W-1];
      q_zero = (prep_q_q[k] == '0);
      mag_q  = q_neg ? -prep_q_q[k] : prep_q_q[k];
      a_le_b = (mag_q <= lsrc_pkg::EDGE_W'(mag_p));
      a_lt_b = (mag_q <  lsrc_pkg::EDGE_W'(mag_p));

      cls_side_d.use_in[k]  = p_neg & (q_neg | q_zero) & a_le_b;
      cls_side_d.use_out[k] = p_pos & ~q_neg & a_lt_b;
      cls_side_d.rej = cls_side_d.rej
                     | (p_zero & q_neg)
                     | (p_neg & (q_neg | q_zero) & ~a_le_b)
                     | (p_pos & q_neg);

      // A ratio is only used when |q| <= |p|, so |q| fits the divider width.
      cls_a_d[k] = mag_q[lsrc_pkg::MAG_W-1:0];
      cls_b_d[k] = mag_p[lsrc_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[lsrc_pkg::ST_CLASS]) begin
      cls_side_q <= cls_side_d;
      cls_a_q    <= cls_a_d;
      cls_b_q    <= cls_b_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider stages: one divider per edge, side data in a matching delay line.
  // ---------------------------------------------------------------------------
  logic [lsrc_pkg::T_W-1:0] ratio [lsrc_pkg::NUM_EDGES];
  side_t                    div_side_q [lsrc_pkg::DIV_STEPS];

  for (genvar e = 0; e < lsrc_pkg::NUM_EDGES; e++) begin : g_div
    lsrc_divider u_div (
      .clk_i  (clk_i),
      .en_i   (adv[lsrc_pkg::ST_DIVN:lsrc_pkg::ST_DIV0]),
      .num_i  (cls_a_q[e]),
      .den_i  (cls_b_q[e]),
      .quot_o (ratio[e])
    );
  end

  for (genvar j = 0; j < lsrc_pkg::DIV_STEPS; j++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv[lsrc_pkg::ST_DIV0 + j]) begin
        div_side_q[j] <= (j == 0) ? cls_side_q : div_side_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Select stage: entry parameter is the largest entry ratio, exit the smallest
  // exit ratio; unused edges fall back to zero and one.
  // ---------------------------------------------------------------------------
  side_t                    sel_side_q;
  logic [lsrc_pkg::T_W-1:0] sel_tin_q, sel_tout_q;
  logic [lsrc_pkg::T_W-1:0] sel_tin_d, sel_tout_d;

  always_comb begin
    logic [lsrc_pkg::T_W-1:0] cin  [lsrc_pkg::NUM_EDGES];
    logic [lsrc_pkg::T_W-1:0] cout [lsrc_pkg::NUM_EDGES];
    logic [lsrc_pkg::T_W-1:0] in_lo, in_hi, out_lo, out_hi;
    side_t                    s;

    s = div_side_q[lsrc_pkg::DIV_STEPS-1];
    for (int k = 0; k < lsrc_pkg::NUM_EDGES; k++) begin
      cin[k]  = s.use_in[k]  ? ratio[k] : '0;
      cout[k] = s.use_out[k] ? ratio[k] : lsrc_pkg::T_ONE;
    end
    in_lo  = (cin[0] > cin[1]) ? cin[0] : cin[1];
    in_hi  = (cin[2] > cin[3]) ? cin[2] : cin[3];
    out_lo = (cout[0] < cout[1]) ? cout[0] : cout[1];
    out_hi = (cout[2] < cout[3]) ? cout[2] : cout[3];
    sel_tin_d  = (in_lo > in_hi) ? in_lo : in_hi;
    sel_tout_d = (out_lo < out_hi) ? out_lo : out_hi;
  end

  always_ff @(posedge clk_i) begin
    if (adv[lsrc_pkg::ST_SEL]) begin
      sel_side_q <= div_side_q[lsrc_pkg::DIV_STEPS-1];
      sel_tin_q  <= sel_tin_d;
      sel_tout_q <= sel_tout_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply stage: t * d, floored by taking the bits above the binary point.
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0]           prod_in_x, prod_in_y, prod_out_x, prod_out_y;
  logic                               mul_vis_q;
  logic signed [lsrc_pkg::COORD_W-1:0] mul_sx_q, mul_sy_q;
  logic signed [lsrc_pkg::COORD_W-1:0] step_in_x_q, step_in_y_q, step_out_x_q, step_out_y_q;

  assign prod_in_x  = $signed({1'b0, sel_tin_q})  * sel_side_q.dx;
  assign prod_in_y  = $signed({1'b0, sel_tin_q})  * sel_side_q.dy;
  assign prod_out_x = $signed({1'b0, sel_tout_q}) * sel_side_q.dx;
  assign prod_out_y = $signed({1'b0, sel_tout_q}) * sel_side_q.dy;

  always_ff @(posedge clk_i) begin
    if (adv[lsrc_pkg::ST_MUL]) begin
      mul_vis_q    <= ~sel_side_q.rej && (sel_tin_q <= sel_tout_q);
      mul_sx_q     <= sel_side_q.sx;
      mul_sy_q     <= sel_side_q.sy;
      step_in_x_q  <= prod_in_x[lsrc_pkg::RATIO_BITS +: lsrc_pkg::COORD_W];
      step_in_y_q  <= prod_in_y[lsrc_pkg::RATIO_BITS +: lsrc_pkg::COORD_W];
      step_out_x_q <= prod_out_x[lsrc_pkg::RATIO_BITS +: lsrc_pkg::COORD_W];
      step_out_y_q <= prod_out_y[lsrc_pkg::RATIO_BITS +: lsrc_pkg::COORD_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: add the steps to the start point; a rejected beat is zero.
  // ---------------------------------------------------------------------------
  lsrc_pkg::out_beat_t out_d, out_q;

  always_comb begin
    out_d.visible         = mul_vis_q;
    out_d.clipped_start_x = mul_vis_q ? mul_sx_q + step_in_x_q  : '0;
    out_d.clipped_start_y = mul_vis_q ? mul_sy_q + step_in_y_q  : '0;
    out_d.clipped_end_x   = mul_vis_q ? mul_sx_q + step_out_x_q : '0;
    out_d.clipped_end_y   = mul_vis_q ? mul_sy_q + step_out_y_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv[lsrc_pkg::ST_OUT]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // A full stage that cannot move on keeps its beat.
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($past(valid_q & ~adv[lsrc_pkg::NUM_ST:1]) & ~valid_q) == '0))
    else $error("pipeline stage lost a beat while blocked");

  // The input side is never stalled while the first stage is empty.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[lsrc_pkg::ST_PREP] |-> !in_stall_o)
    else $error("input stalled with an empty first stage");

  // Selected clip parameters stay within [0, 1].
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[lsrc_pkg::ST_SEL] |->
      (sel_tin_q <= lsrc_pkg::T_ONE) && (sel_tout_q <= lsrc_pkg::T_ONE))
    else $error("clip parameter above one");

  // A rejected segment leaves with all coordinates cleared.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.visible) |->
      (out_data_o.clipped_start_x == '0) && (out_data_o.clipped_start_y == '0) &&
      (out_data_o.clipped_end_x == '0) && (out_data_o.clipped_end_y == '0))
    else $error("rejected beat carries nonzero coordinates");

endmodule
